>>> hw/rtl/dtti_pkg.sv
// Shared types and constants of the decimal text to int64 parser.
package dtti_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAG_W      = VALUE_BITS;
  localparam int ACC_W      = VALUE_BITS + 4;
  localparam int OUT_W      = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ACC_W-1:0] LIMIT_ACC = ACC_W'(1) << (VALUE_BITS - 1);
  localparam logic [MAG_W-1:0] LIMIT_MAG = MAG_W'(1) << (VALUE_BITS - 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_TRAIL  = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        is_end;
    char_class_t cls;
    logic [3:0]  digit;
  } tok_t;

endpackage

>>> hw/rtl/dtti_if.sv
// Valid/ready channel interfaces for the parser's character and result words.
interface dtti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_end;
  modport source (output valid, character, is_end, input ready);
  modport sink   (input valid, character, is_end, output ready);
endinterface

interface dtti_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] value;
  modport source (output valid, status, value, input ready);
  modport sink   (input valid, status, value, output ready);
endinterface

>>> hw/rtl/dtti_front.sv
// Front end: accepts character words and classifies them into tokens.
module dtti_front
  import dtti_pkg::*;
(
  dtti_in_if.sink in_port,
  input  logic    q_full,
  output logic    push,
  output tok_t    push_tok
);

  char_class_t cls;

  always_comb begin
    if (in_port.character == CH_SPACE || in_port.character == CH_TAB) begin
      cls = CLS_BLANK;
    end else if (in_port.character == CH_PLUS) begin
      cls = CLS_PLUS;
    end else if (in_port.character == CH_MINUS) begin
      cls = CLS_MINUS;
    end else if (in_port.character inside {[CH_ZERO:CH_NINE]}) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_port.ready   = !q_full;
  assign push            = in_port.valid && !q_full;
  assign push_tok.is_end = in_port.is_end;
  assign push_tok.cls    = cls;
  assign push_tok.digit  = in_port.character[3:0];

endmodule

>>> hw/rtl/dtti_queue.sv
// Two-entry token queue between front and back end.
module dtti_queue
  import dtti_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output tok_t q_tok
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tok_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_tok   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/dtti_back.sv
// Back end: phase machine, saturating decimal accumulator and result register.
module dtti_back
  import dtti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  tok_t        q_tok,
  output logic        pop,
  dtti_out_if.source  out_port
);

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r;
  status_t            out_status_r, status_nxt;
  logic signed [OUT_W-1:0] out_value_r, value_nxt;

  logic [ACC_W-1:0]   acc;
  logic               acc_over;
  logic [MAG_W-1:0]   mag_digit;
  logic               digit_ovf;
  logic [MAG_W-1:0]   mag_signed;
  logic               load_out;

  // magnitude * 10 + digit; saturate at 2^(VALUE_BITS-1)
  assign acc = (ACC_W'(mag_r) << 3) + (ACC_W'(mag_r) << 1) + ACC_W'(q_tok.digit);
  assign acc_over  = (acc > LIMIT_ACC);
  assign mag_digit = acc_over ? LIMIT_MAG : acc[MAG_W-1:0];
  assign digit_ovf = ovf_r || acc_over;

  assign pop      = q_valid && (!q_tok.is_end || !out_valid_r || out_port.ready);
  assign load_out = pop && q_tok.is_end;

  assign mag_signed = neg_r ? (~mag_r + 1'b1) : mag_r;

  always_comb begin
    status_nxt = ST_OK;
    value_nxt  = '0;
    if (phase_r != PH_DIGITS && phase_r != PH_TRAIL) begin
      status_nxt = ST_MALFORMED;
    end else if (ovf_r || (!neg_r && mag_r == LIMIT_MAG)) begin
      status_nxt = ST_RANGE;
    end else begin
      value_nxt = OUT_W'($signed(mag_signed));
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    if (pop) begin
      if (q_tok.is_end) begin
        phase_nxt = PH_LEAD;
        neg_nxt   = 1'b0;
        mag_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else begin
        case (phase_r)
          PH_LEAD: begin
            if (q_tok.cls == CLS_BLANK) begin
              phase_nxt = PH_LEAD;
            end else if (q_tok.cls == CLS_PLUS || q_tok.cls == CLS_MINUS) begin
              neg_nxt   = (q_tok.cls == CLS_MINUS);
              phase_nxt = PH_SIGN;
            end else if (q_tok.cls == CLS_DIGIT) begin
              mag_nxt   = mag_digit;
              ovf_nxt   = digit_ovf;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
          PH_SIGN: begin
            if (q_tok.cls == CLS_DIGIT) begin
              mag_nxt   = mag_digit;
              ovf_nxt   = digit_ovf;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
          PH_DIGITS: begin
            if (q_tok.cls == CLS_DIGIT) begin
              mag_nxt = mag_digit;
              ovf_nxt = digit_ovf;
            end else if (q_tok.cls == CLS_BLANK) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end
          PH_TRAIL: begin
            if (q_tok.cls != CLS_BLANK) begin
              phase_nxt = PH_ERROR;
            end
          end
          default: begin
            phase_nxt = PH_ERROR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      ovf_r   <= ovf_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_port.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
    end
  end

  assign out_port.valid  = out_valid_r;
  assign out_port.status = out_status_r;
  assign out_port.value  = out_value_r;

endmodule

>>> hw/rtl/decimal_text_to_int64_unit.sv
// Top level of the decimal text to signed 64-bit integer parser.
// Throughput: one character word per cycle, terminators included, while the receiver does not stall the result word.
// Result path: an accepted terminator is written to the token queue and then popped
//   into the result register, whose output drives the result word valid.
// Reset (rst_n low, synchronous) empties the token queue, drops any pending
//   result and returns the parser to the leading-whitespace phase.
module decimal_text_to_int64_unit
  import dtti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dtti_in_if.sink     in_port,
  dtti_out_if.source  out_port
);

  logic q_full;
  logic push;
  tok_t push_tok;
  logic pop;
  logic q_valid;
  tok_t q_tok;

  dtti_front u_front (
    .in_port  (in_port),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  dtti_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  dtti_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .pop      (pop),
    .out_port (out_port)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for decimal_text_to_int64_unit: character words in, checked status/value words out.
module tb;
  import dtti_pkg::*;

  localparam logic [7:0] A_SPACE   = 8'h20;
  localparam logic [7:0] A_TAB     = 8'h09;
  localparam logic [7:0] A_NEWLINE = 8'h0a;
  localparam logic [7:0] A_PLUS    = 8'h2b;
  localparam logic [7:0] A_MINUS   = 8'h2d;
  localparam logic [7:0] A_ZERO    = 8'h30;
  localparam logic [7:0] A_NINE    = 8'h39;
  localparam logic [7:0] A_NUL     = 8'h00;
  localparam logic [7:0] A_ONE_NUL_TWO_0 = 8'h31;
  localparam logic [7:0] A_ONE_NUL_TWO_2 = 8'h32;
  localparam logic [63:0] MAG_CEIL = 64'h8000_0000_0000_0000;
  localparam int IDLE_PCT     = 36;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 90;
  localparam int TAIL_CYCLES  = 20;

  typedef logic [7:0] text_t[$];

  typedef struct {
    status_t            status;
    logic signed [63:0] value;
  } parse_result_t;

  logic clk;
  logic rst_n = 1'b0;

  dtti_in_if  in_ch ();
  dtti_out_if out_ch ();

  decimal_text_to_int64_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  parse_result_t expected_ints[$];
  phase_t        ps_phase;
  logic          ps_negative;
  logic [63:0]   ps_magnitude;
  logic          ps_overflow;

  int  mismatches = 0;
  int  words_sent = 0;
  bit  src_calm   = 1'b0;
  bit  snk_calm   = 1'b0;
  bit  hold_req   = 1'b0;
  int  hold_left  = 0;

  function automatic bit is_blank(logic [7:0] c);
    return c == A_SPACE || c == A_TAB;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= A_ZERO && c <= A_NINE;
  endfunction

  function automatic void clear_parser();
    ps_phase     = PH_LEAD;
    ps_negative  = 1'b0;
    ps_magnitude = '0;
    ps_overflow  = 1'b0;
  endfunction

  function automatic void accumulate(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - A_ZERO);
    if (ps_magnitude > (MAG_CEIL - d) / 10) begin
      ps_magnitude = MAG_CEIL;
      ps_overflow  = 1'b1;
    end else begin
      ps_magnitude = ps_magnitude * 10 + d;
    end
  endfunction

  function automatic void parse_word(logic [7:0] c, logic is_end);
    parse_result_t r;
    if (is_end) begin
      r.value = '0;
      if (ps_phase != PH_DIGITS && ps_phase != PH_TRAIL) begin
        r.status = ST_MALFORMED;
      end else if (ps_overflow || (!ps_negative && ps_magnitude == MAG_CEIL)) begin
        r.status = ST_RANGE;
      end else begin
        r.status = ST_OK;
        r.value  = ps_negative ? 64'(0) - ps_magnitude : ps_magnitude;
      end
      expected_ints.push_back(r);
      clear_parser();
      return;
    end
    case (ps_phase)
      PH_LEAD: begin
        if (is_blank(c)) begin
        end else if (c == A_PLUS || c == A_MINUS) begin
          ps_negative = (c == A_MINUS);
          ps_phase    = PH_SIGN;
        end else if (is_digit(c)) begin
          accumulate(c);
          ps_phase = PH_DIGITS;
        end else begin
          ps_phase = PH_ERROR;
        end
      end
      PH_SIGN: begin
        if (is_digit(c)) begin
          accumulate(c);
          ps_phase = PH_DIGITS;
        end else begin
          ps_phase = PH_ERROR;
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) accumulate(c);
        else if (is_blank(c)) ps_phase = PH_TRAIL;
        else ps_phase = PH_ERROR;
      end
      PH_TRAIL: begin
        if (!is_blank(c)) ps_phase = PH_ERROR;
      end
      default: ps_phase = PH_ERROR;
    endcase
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endfunction

  // receiver: random stalls, calm stretches, and a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_req     <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= snk_calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_ints.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d value=%0d",
                                  out_ch.status, out_ch.value));
      end else begin
        want = expected_ints.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status expected %0d got %0d", want.status, out_ch.status));
        if (out_ch.value !== want.value)
          report_mismatch($sformatf("value expected %0d got %0d", want.value, out_ch.value));
      end
    end
  end

  task automatic send_word(logic [7:0] c, logic is_end);
    while (!src_calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    in_ch.is_end    <= is_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_word(c, is_end);
    words_sent++;
  endtask

  task automatic send_text(text_t text);
    foreach (text[i]) send_word(text[i], 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_string(string s);
    text_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_ints.size() != 0) @(posedge clk);
  endtask

  function automatic void add_blanks(ref text_t text);
    int n;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) text.push_back($urandom_range(1) ? A_SPACE : A_TAB);
  endfunction

  function automatic text_t random_text();
    text_t       text;
    string       digits;
    logic [63:0] mag;
    logic [7:0]  stray;
    int          pick;
    int          form;
    pick = $urandom_range(99);
    if (pick >= 85) begin
      repeat ($urandom_range(6)) text.push_back(8'($urandom_range(255)));
      return text;
    end
    add_blanks(text);
    case ($urandom_range(2))
      1: text.push_back(A_PLUS);
      2: text.push_back(A_MINUS);
      default: ;
    endcase
    form   = $urandom_range(9);
    digits = "";
    if (form <= 5) begin
      mag    = {$urandom, $urandom} >> $urandom_range(63);
      digits = $sformatf("%0d", mag);
    end else if (form <= 7) begin
      mag    = MAG_CEIL - 2 + $urandom_range(3);
      digits = $sformatf("%0d", mag);
    end else if (form == 8) begin
      repeat ($urandom_range(20, 26)) text.push_back(A_ZERO + 8'($urandom_range(9)));
    end else begin
      repeat ($urandom_range(1, 5)) text.push_back(A_ZERO);
      digits = $sformatf("%0d", $urandom_range(999));
    end
    for (int i = 0; i < digits.len(); i++) text.push_back(digits[i]);
    add_blanks(text);
    if (pick >= 70) begin
      case ($urandom_range(5))
        0: stray = A_SPACE;
        1: stray = A_MINUS;
        2: stray = A_NEWLINE;
        3: stray = A_NUL;
        default: stray = 8'($urandom_range(255));
      endcase
      if ($urandom_range(1) && text.size() > 0) text[$urandom_range(text.size() - 1)] = stray;
      else text.insert($urandom_range(text.size()), stray);
    end
    return text;
  endfunction

  task automatic test_directed();
    send_string("");
    send_string("+");
    send_string("-");
    send_string(" \t ");
    send_string("0");
    send_string("-0");
    send_string("+7");
    send_string(" \t-42 \t");
    send_string("9223372036854775807");
    send_string("-9223372036854775808");
    send_string("9223372036854775808");
    send_string("-9223372036854775809");
    send_string("99999999999999999999999");
    send_string("0000000000000000000000000123");
    send_string("- 5");
    send_string("+-5");
    send_string("12 3");
    send_string("12\n");
    send_string("abc");
    send_string("99999999999999999999x");
    send_text('{A_ONE_NUL_TWO_0, A_NUL, A_ONE_NUL_TWO_2});
    send_text('{8'hff, 8'h80});
    send_string("18446744073709551615");
  endtask

  task automatic test_back_to_back();
    src_calm = 1'b1;
    snk_calm = 1'b1;
    repeat (12) send_text(random_text());
    src_calm = 1'b0;
    snk_calm = 1'b0;
  endtask

  task automatic test_result_hold_off();
    text_t text;
    src_calm = 1'b1;
    hold_req <= 1'b1;
    repeat (20) begin
      text = {};
      if ($urandom_range(1)) text.push_back(A_MINUS);
      text.push_back(A_ZERO + 8'($urandom_range(9)));
      send_text(text);
    end
    src_calm = 1'b0;
  endtask

  task automatic test_random_strings();
    int start;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) send_text(random_text());
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.character = '0;
    in_ch.is_end    = 1'b0;
    out_ch.ready    = 1'b0;
    clear_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_back_to_back();
    wait_drained();
    test_result_hold_off();
    wait_drained();
    test_random_strings();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_ints.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> decimal_text_to_int64_unit.f
hw/rtl/dtti_pkg.sv
hw/rtl/dtti_if.sv
hw/rtl/dtti_front.sv
hw/rtl/dtti_queue.sv
hw/rtl/dtti_back.sv
hw/rtl/decimal_text_to_int64_unit.sv
verif/tb.sv
